/* design/eor_pkg.sv */
// Shared types and constants for the ellipse outline rasterizer.
package eor_pkg;

   localparam int DEFAULT_RADIUS_BITS = 8;
   localparam int RADIUS_IN_W = 8;
   localparam int CENTER_W = 11;
   localparam int PIX_W = 12;
   localparam int COLOR_W = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef enum logic [1:0] {
      KIND_FIN = 2'd0,
      KIND_ARC = 2'd1,
      KIND_TIP = 2'd2
   } kind_type;

   // One step's worth of output work. Arc emits all four corners, tip emits
   // the first and the last, finish emits one empty result.
   typedef struct packed {
      kind_type                   kind;
      logic signed [PIX_W-1:0]    px_minus;
      logic signed [PIX_W-1:0]    px_plus;
      logic signed [PIX_W-1:0]    py_plus;
      logic signed [PIX_W-1:0]    py_minus;
      logic        [COLOR_W-1:0]  color;
   } step_desc_type;

endpackage

/* design/eor_front.sv */
// Front end: accepts items, keeps the error terms and classifies each step.
module eor_front import eor_pkg::*; #(
   parameter int RADIUS_BITS = DEFAULT_RADIUS_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_push,
   output logic                        in_full,
   input  logic                        cmd,
   input  logic signed [CENTER_W-1:0]  center_x,
   input  logic signed [CENTER_W-1:0]  center_y,
   input  logic [RADIUS_IN_W-1:0]      half_width,
   input  logic [RADIUS_IN_W-1:0]      half_height,
   input  logic [COLOR_W-1:0]          pixel_color,
   output logic                        q_push,
   output step_desc_type               q_data,
   input  logic                        q_full
);

   localparam int OW = RADIUS_BITS + 2;
   localparam int SQ_W = 2 * RADIUS_BITS;
   localparam int PROD_W = 3 * RADIUS_BITS + 3;
   localparam int TERM_W = 3 * RADIUS_BITS + 5;
   localparam int CW = (RADIUS_BITS + 3 > PIX_W) ? RADIUS_BITS + 3 : PIX_W;

   typedef enum logic [5:0] {
      F_IDLE = 6'b000001,
      F_MUL  = 6'b000010,
      F_INIT = 6'b000100,
      F_SUM  = 6'b001000,
      F_CMP  = 6'b010000,
      F_ACC  = 6'b100000
   } fstate_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_ARC  = 4'b0010,
      PH_TIP  = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   fstate_type                 fstate_ff, fstate_in;
   phase_type                  phase_ff, phase_in;
   logic signed [OW-1:0]       x_ff, x_in;
   logic signed [OW-1:0]       y_ff, y_in;
   logic [RADIUS_BITS-1:0]     a_ff, a_in;
   logic [RADIUS_BITS-1:0]     b_ff, b_in;
   logic signed [CENTER_W-1:0] cx_ff, cx_in;
   logic signed [CENTER_W-1:0] cy_ff, cy_in;
   logic [COLOR_W-1:0]         col_ff, col_in;
   logic [SQ_W-1:0]            aa_ff, aa_in;
   logic [SQ_W-1:0]            bb_ff, bb_in;
   logic signed [TERM_W-1:0]   err_ff, err_in;
   logic signed [TERM_W-1:0]   xinc_ff, xinc_in;
   logic signed [TERM_W-1:0]   yinc_ff, yinc_in;
   logic                       step_x_ff, step_x_in;
   logic                       step_y_ff, step_y_in;

   logic                       accept;
   logic signed [SQ_W:0]       bb_s;
   logic signed [OW-1:0]       one_minus;
   logic signed [PROD_W-1:0]   prod;
   logic signed [TERM_W:0]     e2;
   logic signed [TERM_W-1:0]   add_x, add_y;
   logic signed [OW-1:0]       x_next, y_next, y_tip, b_s;
   logic signed [CW-1:0]       cx_w, cy_w, x_w, y_w, yt_w;

   assign in_full = (fstate_ff != F_IDLE) || q_full;
   assign accept = in_push && !in_full;

   assign bb_s = signed'({1'b0, bb_ff});
   assign one_minus = signed'(OW'(1) - (OW'(a_ff) << 1));
   assign prod = bb_s * one_minus;
   assign e2 = signed'({err_ff, 1'b0});
   assign b_s = signed'(OW'(b_ff));
   assign y_tip = y_ff + OW'(1);

   assign cx_w = CW'(cx_ff);
   assign cy_w = CW'(cy_ff);
   assign x_w = CW'(x_ff);
   assign y_w = CW'(y_ff);
   assign yt_w = CW'(y_tip);

   always_comb begin
      fstate_in = fstate_ff;
      phase_in = phase_ff;
      x_in = x_ff;
      y_in = y_ff;
      a_in = a_ff;
      b_in = b_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      col_in = col_ff;
      aa_in = aa_ff;
      bb_in = bb_ff;
      err_in = err_ff;
      xinc_in = xinc_ff;
      yinc_in = yinc_ff;
      step_x_in = step_x_ff;
      step_y_in = step_y_ff;
      add_x = '0;
      add_y = '0;
      x_next = x_ff;
      y_next = y_ff;
      q_push = 1'b0;
      q_data = '0;
      q_data.kind = KIND_FIN;
      case (fstate_ff)
         F_IDLE: begin
            if (accept) begin
               if (cmd == CMD_START) begin
                  a_in = RADIUS_BITS'(half_width);
                  b_in = RADIUS_BITS'(half_height);
                  cx_in = center_x;
                  cy_in = center_y;
                  col_in = pixel_color;
                  x_in = OW'(0) - OW'(a_in);
                  y_in = '0;
                  phase_in = PH_ARC;
                  fstate_in = F_MUL;
               end else begin
                  q_push = 1'b1;
                  case (phase_ff)
                     PH_ARC: begin
                        q_data.kind = KIND_ARC;
                        q_data.px_minus = PIX_W'(cx_w - x_w);
                        q_data.px_plus = PIX_W'(cx_w + x_w);
                        q_data.py_plus = PIX_W'(cy_w + y_w);
                        q_data.py_minus = PIX_W'(cy_w - y_w);
                        q_data.color = col_ff;
                        fstate_in = F_CMP;
                     end
                     PH_TIP: begin
                        q_data.kind = KIND_TIP;
                        q_data.px_minus = PIX_W'(cx_w);
                        q_data.px_plus = PIX_W'(cx_w);
                        q_data.py_plus = PIX_W'(cy_w + yt_w);
                        q_data.py_minus = PIX_W'(cy_w - yt_w);
                        q_data.color = col_ff;
                        y_in = y_tip;
                        if (y_tip >= b_s) begin
                           phase_in = PH_DONE;
                        end
                     end
                     default: begin
                        q_data.kind = KIND_FIN;
                     end
                  endcase
               end
            end
         end
         F_MUL: begin
            aa_in = a_ff * a_ff;
            bb_in = b_ff * b_ff;
            fstate_in = F_INIT;
         end
         F_INIT: begin
            xinc_in = TERM_W'(prod);
            yinc_in = TERM_W'(aa_ff);
            fstate_in = F_SUM;
         end
         F_SUM: begin
            err_in = xinc_ff + yinc_ff;
            fstate_in = F_IDLE;
         end
         F_CMP: begin
            // decide both moves on the old error, then bump the increments
            step_x_in = (e2 >= xinc_ff);
            step_y_in = (e2 <= yinc_ff);
            if (step_x_in) begin
               xinc_in = xinc_ff + TERM_W'({bb_ff, 1'b0});
            end
            if (step_y_in) begin
               yinc_in = yinc_ff + TERM_W'({aa_ff, 1'b0});
            end
            fstate_in = F_ACC;
         end
         F_ACC: begin
            if (step_x_ff) begin
               add_x = xinc_ff;
               x_next = x_ff + OW'(1);
            end
            if (step_y_ff) begin
               add_y = yinc_ff;
               y_next = y_ff + OW'(1);
            end
            err_in = err_ff + add_x + add_y;
            x_in = x_next;
            y_in = y_next;
            if (x_next > 0) begin
               phase_in = (y_next < b_s) ? PH_TIP : PH_DONE;
            end
            fstate_in = F_IDLE;
         end
         default: begin
            fstate_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fstate_ff <= F_IDLE;
         phase_ff <= PH_IDLE;
      end else begin
         fstate_ff <= fstate_in;
         phase_ff <= phase_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      a_ff <= a_in;
      b_ff <= b_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      col_ff <= col_in;
      aa_ff <= aa_in;
      bb_ff <= bb_in;
      err_ff <= err_in;
      xinc_ff <= xinc_in;
      yinc_ff <= yinc_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
   end

endmodule

/* design/eor_queue.sv */
// Short queue of step descriptors between the front and back ends.
module eor_queue import eor_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  step_desc_type push_data,
   output logic          full,
   input  logic          pop,
   output step_desc_type pop_data,
   output logic          empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   step_desc_type    mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/eor_back.sv */
// Back end: expands each step descriptor into its pixel results.
module eor_back import eor_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  step_desc_type            q_data,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     out_empty,
   input  logic                     out_pop,
   output logic signed [PIX_W-1:0]  pixel_x,
   output logic signed [PIX_W-1:0]  pixel_y,
   output logic [COLOR_W-1:0]       color_out,
   output logic                     pixel_valid,
   output logic                     last_of_step,
   output logic                     finished
);

   step_desc_type desc_ff, desc_in;
   logic          busy_ff, busy_in;
   logic [1:0]    idx_ff, idx_in;
   logic          transfer;
   logic          last;

   assign last = (desc_ff.kind == KIND_FIN) || (idx_ff == 2'd3);
   assign transfer = out_pop && busy_ff;
   assign q_pop = !q_empty && (!busy_ff || (transfer && last));

   always_comb begin
      desc_in = desc_ff;
      busy_in = busy_ff;
      idx_in = idx_ff;
      if (q_pop) begin
         desc_in = q_data;
         busy_in = 1'b1;
         idx_in = 2'd0;
      end else if (transfer) begin
         if (last) begin
            busy_in = 1'b0;
         end else if (desc_ff.kind == KIND_TIP) begin
            // tip uses only the outer two corners
            idx_in = 2'd3;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
      desc_ff <= desc_in;
   end

   assign out_empty = !busy_ff;
   assign pixel_x = (idx_ff == 2'd0 || idx_ff == 2'd3) ? desc_ff.px_minus : desc_ff.px_plus;
   assign pixel_y = (idx_ff == 2'd0 || idx_ff == 2'd1) ? desc_ff.py_plus : desc_ff.py_minus;
   assign color_out = desc_ff.color;
   assign pixel_valid = (desc_ff.kind != KIND_FIN);
   assign finished = (desc_ff.kind == KIND_FIN);
   assign last_of_step = last;

endmodule

/* design/ellipse_outline_raster_unit.sv */
// Ellipse outline rasterizer top level: front end, step queue and pixel back end.
// Integer error-term ellipse outline rasterizer. A start item (cmd 0) latches the
// center, radii and color and then sets up the error terms in the front end (two
// multiply stages and a sum); it emits nothing. An arc step updates the terms in
// the compare and accumulate states and yields four mirrored pixels, a tip step
// yields two, and a step while idle or after completion yields one empty result
// with finished set. The back end delivers one result per cycle while pop is held;
// a two-entry step queue lets the front end run ahead of a stalled pixel sink.
module ellipse_outline_raster_unit import eor_pkg::*; #(
   parameter int RADIUS_BITS = DEFAULT_RADIUS_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_cmd,
   input  logic signed [CENTER_W-1:0]  req_center_x,
   input  logic signed [CENTER_W-1:0]  req_center_y,
   input  logic [RADIUS_IN_W-1:0]      req_half_width,
   input  logic [RADIUS_IN_W-1:0]      req_half_height,
   input  logic [COLOR_W-1:0]          req_pixel_color,
   output logic                        empty,
   input  logic                        pop,
   output logic signed [PIX_W-1:0]     rsp_pixel_x,
   output logic signed [PIX_W-1:0]     rsp_pixel_y,
   output logic [COLOR_W-1:0]          rsp_color_out,
   output logic                        rsp_pixel_valid,
   output logic                        rsp_last_of_step,
   output logic                        rsp_finished
);

   step_desc_type front_desc;
   step_desc_type queue_desc;
   logic          front_push;
   logic          queue_full;
   logic          queue_empty;
   logic          back_pop;

   eor_front #(
      .RADIUS_BITS(RADIUS_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_push    (push),
      .in_full    (full),
      .cmd        (req_cmd),
      .center_x   (req_center_x),
      .center_y   (req_center_y),
      .half_width (req_half_width),
      .half_height(req_half_height),
      .pixel_color(req_pixel_color),
      .q_push     (front_push),
      .q_data     (front_desc),
      .q_full     (queue_full)
   );

   eor_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_data(front_desc),
      .full     (queue_full),
      .pop      (back_pop),
      .pop_data (queue_desc),
      .empty    (queue_empty)
   );

   eor_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_data      (queue_desc),
      .q_empty     (queue_empty),
      .q_pop       (back_pop),
      .out_empty   (empty),
      .out_pop     (pop),
      .pixel_x     (rsp_pixel_x),
      .pixel_y     (rsp_pixel_y),
      .color_out   (rsp_color_out),
      .pixel_valid (rsp_pixel_valid),
      .last_of_step(rsp_last_of_step),
      .finished    (rsp_finished)
   );

endmodule
